### rtl/tx_request_id_tracker_assert.svh
// assertion macros for the transmit request id tracker
`ifndef TX_REQUEST_ID_TRACKER_ASSERT_SVH
`define TX_REQUEST_ID_TRACKER_ASSERT_SVH

// property checked on every rising edge outside reset
`define TXRIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication checked outside reset
`define TXRIT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/txrit_pkg.sv
// shared types and constants of the transmit request id tracker
package txrit_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int TIME_BITS       = 48;
    localparam int DESC_BITS       = 6;
    localparam int ID_BITS         = 10;
    localparam int TYPE_BITS       = 2;
    localparam int STATUS_BITS     = 3;
    localparam int MISSED_BITS     = 11;
    localparam int QLOG_BITS       = 4;
    localparam int K_BITS          = 5;
    localparam int THRESH_BITS     = 32;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 48;

    localparam logic [QLOG_BITS-1:0]   QLOG_RESET   = 4'd10;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 32'hffff_ffff;

    localparam logic [CFG_IDX_BITS-1:0] CFG_QSIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 2'd2;

    typedef enum logic [TYPE_BITS-1:0] {
        REQ_SUBMIT   = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_CHECK    = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_NO_FREE_ID = 3'd2,
        ST_MISSED_IRQ = 3'd3,
        ST_TOO_MANY   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic                 busy;
        logic [DESC_BITS-1:0] descs;
        logic [TIME_BITS-1:0] stamp;
    } entry_t;

endpackage

### rtl/txrit_if.sv
// request, response and configuration channel interfaces
interface txrit_req_if;
    import txrit_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TYPE_BITS-1:0] req_type;
    logic [ID_BITS-1:0]   req_id;
    logic [DESC_BITS-1:0] desc_count;
    logic [TIME_BITS-1:0] now_time;

    modport source (output valid, req_type, req_id, desc_count, now_time, input ready);
    modport sink (input valid, req_type, req_id, desc_count, now_time, output ready);
endinterface

interface txrit_rsp_if;
    import txrit_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     id_out;
    logic [DESC_BITS-1:0]   desc_released;
    logic [MISSED_BITS-1:0] missed_count;

    modport source (output valid, status, id_out, desc_released, missed_count, input ready);
    modport sink (input valid, status, id_out, desc_released, missed_count, output ready);
endinterface

interface txrit_cfg_if;
    import txrit_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/tx_request_id_tracker.sv
// transmit request id tracker: free id ring, per-id records and timeout scan
//
// req carries one item: submit, completion or missing-completion check.
// rsp returns exactly one result item per request item, in order.
// cfg writes a register (0 ring size log2, 1 timeout, 2 missed threshold);
// it is always ready and is meant to be written only while the block is idle.
// submit, completion and unknown types: the accepted item is registered and
// its result is formed in the EXEC state, loaded once the output register is
// free; no new item is taken before that. the ring and entry record memories
// are read in the accept cycle and written back from the EXEC state.
// check: the scan reads one entry record per cycle over the ring in use.
// after reset a clearing pass over all MAX_ENTRIES entries loads the free id ring
// with its identity values and clears every busy flag; req.ready stays low
// until it ends.
// a result waits in the output register while rsp.ready is low; the next
// item is still accepted, and its result waits until the register is free.
module tx_request_id_tracker #(
    parameter int MAX_ENTRIES = txrit_pkg::MAX_ENTRIES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    txrit_req_if.sink   req,
    txrit_rsp_if.source rsp,
    txrit_cfg_if.sink   cfg
);
    import txrit_pkg::*;
    `include "tx_request_id_tracker_assert.svh"

    localparam int AW      = $clog2(MAX_ENTRIES);
    localparam int LOG_MAX = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int SZW     = LOG_MAX + 1;
    localparam int RW      = (AW > ID_BITS) ? AW : ID_BITS;
    localparam int RCW     = (SZW > ID_BITS) ? SZW : ID_BITS;
    localparam int CW      = (SZW > MISSED_BITS) ? SZW : MISSED_BITS;
    localparam logic [AW-1:0]     CLR_LAST = AW'(MAX_ENTRIES - 1);
    localparam logic [K_BITS-1:0] K_MAX    = K_BITS'(LOG_MAX);

    state_t state_reg, state_next;

    logic [QLOG_BITS-1:0]   qlog_reg;
    logic [TIME_BITS-1:0]   timeout_reg;
    logic [THRESH_BITS-1:0] thresh_reg;

    logic [AW-1:0]  alloc_reg, alloc_next;
    logic [AW-1:0]  clean_reg, clean_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [SZW-1:0] outst_reg, outst_next;
    logic [SZW-1:0] scan_reg, scan_next;
    logic [SZW-1:0] count_reg, count_next;
    logic           irq_reg, irq_next;
    logic           pv_reg, pv_next;
    logic           fault_reg, fault_next;

    logic [TYPE_BITS-1:0] type_reg;
    logic [ID_BITS-1:0]   rid_reg;
    logic [DESC_BITS-1:0] dc_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic                   rsp_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [DESC_BITS-1:0]   desc_reg;
    logic [MISSED_BITS-1:0] missed_reg;

    entry_t        ent_mem [MAX_ENTRIES];
    logic [AW-1:0] ring_mem [MAX_ENTRIES];
    entry_t        ent_rd_reg;
    logic [AW-1:0] ring_rd_reg;

    logic          ent_we, ent_re, ring_we, ring_re;
    logic [AW-1:0] ent_waddr, ent_raddr, ring_waddr, ring_raddr, ring_wdata;
    entry_t        ent_wdata, ent_freed, ent_new;

    logic                   accept, out_free, load;
    status_t                res_status;
    logic [ID_BITS-1:0]     res_id;
    logic [DESC_BITS-1:0]   res_desc;
    logic [MISSED_BITS-1:0] res_missed;

    logic [K_BITS-1:0] k_raw, k_eff;
    logic [SZW-1:0]    size_w;
    logic [AW-1:0]     mask_aw;
    logic [RW-1:0]     rid_wide_in, rid_wide_reg, ring_id_wide;
    logic [AW-1:0]     rid_addr_in, rid_addr_reg;
    logic              rid_bad, issuing;
    logic [CW-1:0]     count_wide;
    logic [TIME_BITS:0] age_full;
    logic              aged, over1, over2;

    // ring size in use
    assign k_raw   = (qlog_reg == '0) ? K_BITS'(1) : K_BITS'(qlog_reg);
    assign k_eff   = (k_raw > K_MAX) ? K_MAX : k_raw;
    assign size_w  = SZW'(1) << k_eff;
    assign mask_aw = AW'(size_w - SZW'(1));

    assign rid_wide_in  = RW'(req.req_id);
    assign rid_addr_in  = rid_wide_in[AW-1:0];
    assign rid_wide_reg = RW'(rid_reg);
    assign rid_addr_reg = rid_wide_reg[AW-1:0];
    assign ring_id_wide = RW'(ring_rd_reg);
    assign rid_bad      = RCW'(rid_reg) >= RCW'(size_w);
    assign count_wide   = CW'(count_reg);

    // age of the entry read back during a scan
    assign age_full = {1'b0, now_reg} - {1'b0, ent_rd_reg.stamp};
    assign aged     = ent_rd_reg.busy && !age_full[TIME_BITS] && (age_full != '0);
    assign over1    = aged && (age_full[TIME_BITS-1:0] > timeout_reg);
    assign over2    = aged && (age_full > {timeout_reg, 1'b0});

    assign ent_freed = '{busy: 1'b0, descs: ent_rd_reg.descs, stamp: ent_rd_reg.stamp};
    assign ent_new   = '{busy: 1'b1, descs: dc_reg, stamp: now_reg};

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign issuing   = (state_reg == S_SCAN) && (scan_reg != size_w);

    assign ring_re    = accept;
    assign ring_raddr = alloc_reg & mask_aw;

    assign cfg.ready = 1'b1;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.id_out        = id_reg;
    assign rsp.desc_released = desc_reg;
    assign rsp.missed_count  = missed_reg;

    always_comb
    begin
        state_next = state_reg;
        alloc_next = alloc_reg;
        clean_next = clean_reg;
        clr_next   = clr_reg;
        outst_next = outst_reg;
        scan_next  = scan_reg;
        count_next = count_reg;
        irq_next   = irq_reg;
        pv_next    = 1'b0;
        fault_next = fault_reg;
        ent_we     = 1'b0;
        ent_waddr  = clr_reg;
        ent_wdata  = '0;
        ent_re     = 1'b0;
        ent_raddr  = rid_addr_in;
        ring_we    = 1'b0;
        ring_waddr = clr_reg;
        ring_wdata = clr_reg;
        load       = 1'b0;
        res_status = ST_OK;
        res_id     = '0;
        res_desc   = '0;
        res_missed = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ent_we  = 1'b1;
                ring_we = 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ent_re = 1'b1;
                    if (req.req_type == REQ_CHECK)
                    begin
                        state_next = S_SCAN;
                        scan_next  = '0;
                        count_next = '0;
                        fault_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                pv_next = issuing;
                if (issuing)
                begin
                    ent_re    = 1'b1;
                    ent_raddr = scan_reg[AW-1:0];
                    scan_next = scan_reg + SZW'(1);
                end
                if (pv_reg)
                begin
                    if (!irq_reg && over2)
                    begin
                        fault_next = 1'b1;
                    end
                    if (over1)
                    begin
                        count_next = count_reg + SZW'(1);
                    end
                end
                if (!issuing && !pv_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    case (type_reg)
                        REQ_SUBMIT:
                        begin
                            if (outst_reg >= size_w)
                            begin
                                res_status = ST_NO_FREE_ID;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                ent_waddr  = ring_rd_reg;
                                ent_wdata  = ent_new;
                                alloc_next = (alloc_reg + AW'(1)) & mask_aw;
                                outst_next = outst_reg + SZW'(1);
                                res_id     = ring_id_wide[ID_BITS-1:0];
                            end
                        end
                        REQ_COMPLETE:
                        begin
                            irq_next = 1'b1;
                            res_id   = rid_reg;
                            if (rid_bad || !ent_rd_reg.busy)
                            begin
                                res_status = ST_BAD_ID;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                ent_waddr  = rid_addr_reg;
                                ent_wdata  = ent_freed;
                                res_desc   = ent_rd_reg.descs;
                                ring_we    = 1'b1;
                                ring_waddr = clean_reg & mask_aw;
                                ring_wdata = rid_addr_reg;
                                clean_next = (clean_reg + AW'(1)) & mask_aw;
                                if (outst_reg != '0)
                                begin
                                    outst_next = outst_reg - SZW'(1);
                                end
                            end
                        end
                        REQ_CHECK:
                        begin
                            if (fault_reg)
                            begin
                                res_status = ST_MISSED_IRQ;
                            end
                            else
                            begin
                                res_missed = count_wide[MISSED_BITS-1:0];
                                if (THRESH_BITS'(count_reg) > thresh_reg)
                                begin
                                    res_status = ST_TOO_MANY;
                                end
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            alloc_reg     <= '0;
            clean_reg     <= '0;
            clr_reg       <= '0;
            outst_reg     <= '0;
            scan_reg      <= '0;
            count_reg     <= '0;
            irq_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            fault_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alloc_reg <= alloc_next;
            clean_reg <= clean_next;
            clr_reg   <= clr_next;
            outst_reg <= outst_next;
            scan_reg  <= scan_next;
            count_reg <= count_next;
            irq_reg   <= irq_next;
            pv_reg    <= pv_next;
            fault_reg <= fault_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlog_reg    <= QLOG_RESET;
            timeout_reg <= '1;
            thresh_reg  <= THRESH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_QSIZE_LOG2: qlog_reg    <= cfg.data[QLOG_BITS-1:0];
                CFG_TIMEOUT:    timeout_reg <= cfg.data[TIME_BITS-1:0];
                CFG_THRESHOLD:  thresh_reg  <= cfg.data[THRESH_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // accepted item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req.req_type;
            rid_reg  <= req.req_id;
            dc_reg   <= req.desc_count;
            now_reg  <= req.now_time;
        end
        if (load)
        begin
            status_reg <= res_status;
            id_reg     <= res_id;
            desc_reg   <= res_desc;
            missed_reg <= res_missed;
        end
    end

    // per-id record memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rd_reg <= ent_mem[ent_raddr];
        end
    end

    // free id ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[ring_raddr];
        end
    end

    `TXRIT_ASSERT_IMPL(a_ready_only_idle, req.ready, state_reg == S_IDLE, "item taken while busy")
    `TXRIT_ASSERT_IMPL(a_load_slot_free, load, !rsp_valid_reg || rsp.ready, "result overwritten")
    `TXRIT_ASSERT_IMPL(a_scan_pipe, pv_reg, state_reg == S_SCAN, "scan data outside a scan")
    `TXRIT_ASSERT(a_result_from_exec, $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC), "stray result")

endmodule

### tb/tb_tx_request_id_tracker.sv
// testbench for the transmit request id tracker: directed and random items checked in order
`timescale 1ns / 1ps

module tb_tx_request_id_tracker;
    import txrit_pkg::*;

    localparam logic [TYPE_BITS-1:0] REQ_UNKNOWN   = 2'd3;
    localparam int                   RING_LOG2_MAX = $clog2(MAX_ENTRIES_DEF);
    localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = '1;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ID_BITS-1:0]     id;
        logic [DESC_BITS-1:0]   descs;
        logic [MISSED_BITS-1:0] missed;
    } tracker_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    txrit_req_if req_bus ();
    txrit_rsp_if rsp_bus ();
    txrit_cfg_if cfg_bus ();

    tx_request_id_tracker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // predicted tracker state
    logic [ID_BITS-1:0]     id_ring [MAX_ENTRIES_DEF];
    bit                     id_busy [MAX_ENTRIES_DEF];
    logic [TIME_BITS-1:0]   id_stamp [MAX_ENTRIES_DEF];
    logic [DESC_BITS-1:0]   id_descs [MAX_ENTRIES_DEF];
    logic [ID_BITS-1:0]     alloc_ptr;
    logic [ID_BITS-1:0]     clean_ptr;
    int unsigned            live_count;
    bit                     irq_seen;
    logic [QLOG_BITS-1:0]   qsize_log2;
    logic [TIME_BITS-1:0]   timeout_units;
    logic [THRESH_BITS-1:0] missed_limit;

    tracker_result_t        pending_results [$];
    int                     err_count   = 0;
    bit                     sender_gaps = 1'b1;
    bit                     sink_stalls = 1'b1;
    int                     hold_len    = 0;
    bit                     hold_toggle = 1'b0;
    logic [TIME_BITS-1:0]   clock_now   = '0;
    int                     time_step   = 50;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_BITS-1:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[TIME_BITS-1:0];
    endfunction

    function automatic int unsigned ring_entries();
        int unsigned k;
        k = qsize_log2;
        if (k == 0)
            k = 1;
        if (k > RING_LOG2_MAX)
            k = RING_LOG2_MAX;
        return 32'd1 << k;
    endfunction

    task automatic init_tracker_model();
        for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        begin
            id_ring[i]  = ID_BITS'(i);
            id_busy[i]  = 1'b0;
            id_stamp[i] = '0;
            id_descs[i] = '0;
        end
        alloc_ptr     = '0;
        clean_ptr     = '0;
        live_count    = 0;
        irq_seen      = 1'b0;
        qsize_log2    = QLOG_RESET;
        timeout_units = TIME_ALL_ONES;
        missed_limit  = THRESH_RESET;
    endtask

    // advances the predicted state by one item and returns its result
    function automatic tracker_result_t track_request(input logic [TYPE_BITS-1:0] kind,
            input logic [ID_BITS-1:0] rid, input logic [DESC_BITS-1:0] dc,
            input logic [TIME_BITS-1:0] now);
        tracker_result_t    res;
        int unsigned        size;
        int unsigned        hits;
        logic [ID_BITS-1:0] id;
        logic [63:0]        age;
        logic [63:0]        limit;
        bit                 fault;
        res   = '0;
        size  = ring_entries();
        hits  = 0;
        fault = 1'b0;
        limit = timeout_units;
        case (kind)
            REQ_SUBMIT:
            begin
                if (live_count >= size)
                    res.status = ST_NO_FREE_ID;
                else
                begin
                    id           = id_ring[alloc_ptr & (size - 1)];
                    id_busy[id]  = 1'b1;
                    id_stamp[id] = now;
                    id_descs[id] = dc;
                    alloc_ptr    = ID_BITS'((alloc_ptr + 1) & (size - 1));
                    live_count++;
                    res.id = id;
                end
            end
            REQ_COMPLETE:
            begin
                irq_seen = 1'b1;
                res.id   = rid;
                if (rid >= size || !id_busy[rid])
                    res.status = ST_BAD_ID;
                else
                begin
                    id_busy[rid] = 1'b0;
                    res.descs    = id_descs[rid];
                    id_ring[clean_ptr & (size - 1)] = rid;
                    clean_ptr = ID_BITS'((clean_ptr + 1) & (size - 1));
                    if (live_count > 0)
                        live_count--;
                end
            end
            REQ_CHECK:
            begin
                for (int i = 0; i < size; i++)
                begin
                    if (!id_busy[i] || now <= id_stamp[i])
                        continue;
                    age = now - id_stamp[i];
                    // without any completion, twice the timeout means a lost interrupt
                    if (!irq_seen && age > limit && age - limit > limit)
                    begin
                        fault = 1'b1;
                        break;
                    end
                    if (age > limit)
                        hits++;
                end
                if (fault)
                    res.status = ST_MISSED_IRQ;
                else
                begin
                    res.missed = MISSED_BITS'(hits);
                    if (hits > missed_limit)
                        res.status = ST_TOO_MANY;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        err_count++;
        $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic send_item(input logic [TYPE_BITS-1:0] kind, input logic [ID_BITS-1:0] rid,
                             input logic [DESC_BITS-1:0] dc, input logic [TIME_BITS-1:0] now);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.req_id     <= rid;
        req_bus.desc_count <= dc;
        req_bus.now_time   <= now;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        pending_results.push_back(track_request(kind, rid, dc, now));
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        case (idx)
            CFG_QSIZE_LOG2: qsize_log2    = value[QLOG_BITS-1:0];
            CFG_TIMEOUT:    timeout_units = value[TIME_BITS-1:0];
            CFG_THRESHOLD:  missed_limit  = value[THRESH_BITS-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // registers only change with the block idle; unused data bits are random
    task automatic set_tracker_config(input logic [QLOG_BITS-1:0] qlog,
                                      input logic [TIME_BITS-1:0] tmo,
                                      input logic [THRESH_BITS-1:0] lim);
        logic [CFG_DATA_BITS-1:0] word;
        drain_results();
        word = rand48();
        word[QLOG_BITS-1:0] = qlog;
        write_register(CFG_QSIZE_LOG2, word);
        write_register(CFG_TIMEOUT, tmo);
        word = rand48();
        word[THRESH_BITS-1:0] = lim;
        write_register(CFG_THRESHOLD, word);
    endtask

    function automatic int pick_live_id();
        int unsigned size;
        int unsigned start;
        size  = ring_entries();
        start = $urandom_range(0, size - 1);
        for (int k = 0; k < size; k++)
        begin
            if (id_busy[(start + k) & (size - 1)])
                return (start + k) & (size - 1);
        end
        return -1;
    endfunction

    task automatic release_outstanding();
        int live;
        live = pick_live_id();
        while (live >= 0)
        begin
            send_item(REQ_COMPLETE, ID_BITS'(live), DESC_BITS'($urandom_range(0, 63)),
                      clock_now);
            live = pick_live_id();
        end
    endtask

    // mostly well-formed submit / complete / check traffic, some noise items
    task automatic random_traffic(input int count, input int check_pct);
        int                 r;
        int                 live;
        logic [ID_BITS-1:0] rid;
        repeat (count)
        begin
            r         = $urandom_range(0, 99);
            clock_now = clock_now + $urandom_range(0, time_step);
            rid       = ID_BITS'($urandom_range(0, MAX_ENTRIES_DEF - 1));
            if (r < 6)
                send_item(TYPE_BITS'($urandom_range(0, 3)), rid,
                          DESC_BITS'($urandom_range(0, 63)), rand48());
            else if (r < 6 + check_pct)
                send_item(REQ_CHECK, rid, DESC_BITS'($urandom_range(0, 63)), clock_now);
            else if (live_count >= ring_entries() || (live_count != 0 && $urandom_range(0, 1)))
            begin
                live = pick_live_id();
                if (live >= 0 && $urandom_range(0, 9) != 0)
                    rid = ID_BITS'(live);
                send_item(REQ_COMPLETE, rid, DESC_BITS'($urandom_range(0, 63)), clock_now);
            end
            else
                send_item(REQ_SUBMIT, rid, DESC_BITS'($urandom_range(0, 63)), clock_now);
        end
    endtask

    // must run before any completion has been seen
    task automatic test_missed_interrupt();
        set_tracker_config(4'd3, 48'd10, THRESH_RESET);
        send_item(REQ_SUBMIT, 10'd0, 6'h3f, 48'd100);
        send_item(REQ_SUBMIT, 10'h3ff, 6'h00, 48'd100);
        // nothing aged yet
        send_item(REQ_CHECK, 10'd0, 6'd0, 48'd105);
        // stamps ahead of now
        send_item(REQ_CHECK, 10'd0, 6'd0, 48'd50);
        // aged, first under and then over twice the timeout
        send_item(REQ_CHECK, 10'd0, 6'd0, 48'd115);
        send_item(REQ_CHECK, 10'd0, 6'd0, 48'd121);
        send_item(REQ_UNKNOWN, 10'h3ff, 6'h3f, TIME_ALL_ONES);
    endtask

    task automatic test_ring_empty();
        repeat (5)
            send_item(REQ_SUBMIT, ID_BITS'($urandom_range(0, 1023)),
                      DESC_BITS'($urandom_range(0, 63)), 48'd200);
        send_item(REQ_SUBMIT, 10'h155, 6'h2a, TIME_ALL_ONES);
        // every id of the eight-entry ring is out now
        send_item(REQ_SUBMIT, 10'h2aa, 6'h15, 48'd300);
        send_item(REQ_CHECK, 10'd0, 6'd0, TIME_ALL_ONES);
    endtask

    task automatic test_completions();
        send_item(REQ_COMPLETE, 10'd0, 6'd0, 48'd0);
        // already freed
        send_item(REQ_COMPLETE, 10'd0, 6'd0, 48'd0);
        // outside the ring in use
        send_item(REQ_COMPLETE, 10'h3ff, 6'd0, 48'd0);
        send_item(REQ_COMPLETE, 10'd1, 6'h3f, TIME_ALL_ONES);
        send_item(REQ_CHECK, 10'd0, 6'd0, TIME_ALL_ONES);
        set_tracker_config(4'd3, 48'd10, '0);
        send_item(REQ_CHECK, 10'd0, 6'd0, 48'd1000);
        set_tracker_config(4'd3, TIME_ALL_ONES, THRESH_RESET);
        send_item(REQ_CHECK, 10'd0, 6'd0, 48'd1000);
    endtask

    // growing the ring brings a still busy id under the allocation pointer
    task automatic test_id_reuse();
        set_tracker_config(4'd4, 48'd10, THRESH_RESET);
        repeat (3)
            send_item(REQ_SUBMIT, ID_BITS'($urandom_range(0, 1023)),
                      DESC_BITS'($urandom_range(0, 63)), 48'd400);
        send_item(REQ_CHECK, 10'd0, 6'd0, 48'd500);
    endtask

    task automatic test_backpressure();
        clock_now = 48'd5000;
        time_step = 50;
        release_outstanding();
        set_tracker_config(4'd2, 48'd200, 32'd1);
        sender_gaps = 1'b0;
        hold_len    = 150;
        hold_toggle = ~hold_toggle;
        random_traffic(24, 10);
        // sender waits for every result before going on
        drain_results();
        sink_stalls = 1'b0;
        random_traffic(40, 10);
        sink_stalls = 1'b1;
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [QLOG_BITS-1:0]   qlog;
        logic [TIME_BITS-1:0]   tmo;
        logic [THRESH_BITS-1:0] lim;
        for (int phase = 0; phase < 13; phase++)
        begin
            case (phase)
                0:       qlog = 4'd0;
                1:       qlog = 4'd15;
                2:       qlog = QLOG_BITS'(RING_LOG2_MAX);
                3:       qlog = 4'd1;
                4:       qlog = 4'd11;
                default: qlog = QLOG_BITS'($urandom_range(1, 6));
            endcase
            time_step = $urandom_range(1, 2000);
            case (phase)
                5:       tmo = '0;
                6:       tmo = TIME_ALL_ONES;
                default: tmo = TIME_BITS'(time_step * $urandom_range(2, 40));
            endcase
            case (phase)
                7:       lim = THRESH_RESET;
                8:       lim = '0;
                default: lim = $urandom_range(0, 6);
            endcase
            if ($urandom_range(0, 1))
                release_outstanding();
            set_tracker_config(qlog, tmo, lim);
            // timestamps wrap around during this phase
            if (phase == 9)
                clock_now = TIME_ALL_ONES - 48'd5000;
            if (ring_entries() >= 256)
                random_traffic(40, 2);
            else
                random_traffic(70, 12);
        end
    endtask

    initial
    begin : sink_pacing
        int hold_left;
        int stall_left;
        bit hold_seen;
        hold_left     = 0;
        stall_left    = 0;
        hold_seen     = 1'b0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 99) < 30)
            begin
                stall_left = pick_gap();
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        tracker_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with none pending, status", 0, rsp_bus.status);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_bus.status !== want.status)
                    report_mismatch("status", want.status, rsp_bus.status);
                if (rsp_bus.id_out !== want.id)
                    report_mismatch("id_out", want.id, rsp_bus.id_out);
                if (rsp_bus.desc_released !== want.descs)
                    report_mismatch("desc_released", want.descs, rsp_bus.desc_released);
                if (rsp_bus.missed_count !== want.missed)
                    report_mismatch("missed_count", want.missed, rsp_bus.missed_count);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        req_bus.valid      = 1'b0;
        req_bus.req_type   = '0;
        req_bus.req_id     = '0;
        req_bus.desc_count = '0;
        req_bus.now_time   = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        init_tracker_model();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        // the clearing pass holds off requests after reset
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        test_missed_interrupt();
        test_ring_empty();
        test_completions();
        test_id_reuse();
        test_backpressure();
        test_random_phases();
        drain_results();
        repeat (MAX_ENTRIES_DEF + 16) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/txrit_pkg.sv
rtl/txrit_if.sv
rtl/tx_request_id_tracker.sv
tb/tb_tx_request_id_tracker.sv
